// ===== rtl/scap_pkg.sv =====
package scap_pkg;

    localparam logic [3:0] MAX_GROUPS = 4'd8;

    localparam logic [7:0] TS_INVERSE = 8'h3F;
    localparam logic [7:0] TS_DIRECT  = 8'h3B;
    localparam logic [3:0] PROTO_T0   = 4'd0;
    localparam logic [3:0] PROTO_T1   = 4'd1;
    localparam logic [3:0] PROTO_T15  = 4'd15;

    typedef enum logic [2:0] {
        PH_TS    = 3'd0,
        PH_T0    = 3'd1,
        PH_IFACE = 3'd2,
        PH_HIST  = 3'd3,
        PH_TCK   = 3'd4,
        PH_DONE  = 3'd5,
        PH_ERR   = 3'd6
    } phase_t;

    localparam logic [3:0] KIND_TS    = 4'd0;
    localparam logic [3:0] KIND_T0    = 4'd1;
    localparam logic [3:0] KIND_TA    = 4'd2;
    localparam logic [3:0] KIND_TB    = 4'd3;
    localparam logic [3:0] KIND_TC    = 4'd4;
    localparam logic [3:0] KIND_TD    = 4'd5;
    localparam logic [3:0] KIND_HIST  = 4'd6;
    localparam logic [3:0] KIND_TCK   = 4'd7;
    localparam logic [3:0] KIND_EXTRA = 4'd8;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_BAD_TS    = 3'd1;
    localparam logic [2:0] ERR_BAD_TD1   = 3'd2;
    localparam logic [2:0] ERR_BAD_TA2   = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED = 3'd4;
    localparam logic [2:0] ERR_GROUPS    = 3'd5;

    localparam logic [1:0] PROT_NONE = 2'd0;
    localparam logic [1:0] PROT_T0   = 2'd1;
    localparam logic [1:0] PROT_T1   = 2'd2;

    typedef struct packed {
        phase_t     phase;
        logic [3:0] pend;
        logic [3:0] group;
        logic [3:0] hist_left;
        logic [3:0] hist_count;
        logic       inverse;
        logic [1:0] chosen;
        logic [2:0] mask;
        logic       ta2_present;
        logic [3:0] ta2_nibble;
        logic [2:0] err;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:       PH_TS,
        pend:        4'd0,
        group:       4'd1,
        hist_left:   4'd0,
        hist_count:  4'd0,
        inverse:     1'b0,
        chosen:      PROT_NONE,
        mask:        3'd0,
        ta2_present: 1'b0,
        ta2_nibble:  4'd0,
        err:         ERR_NONE
    };

    typedef struct packed {
        logic [3:0] kind;
        logic [3:0] group;
        logic [7:0] value;
        logic       done;
        logic [2:0] err;
        logic       convention;
        logic [1:0] default_protocol;
        logic [2:0] supported;
        logic [3:0] hist_len;
        logic       check_byte;
    } parse_result_t;

endpackage

// ===== rtl/scap_step.sv =====
module scap_step
    import scap_pkg::*;
(
    input  parse_state_t  state,
    input  logic [7:0]    atr_byte,
    input  logic          last_byte,
    output parse_state_t  state_next,
    output parse_result_t result
);

    parse_state_t nx;
    logic [3:0]   kind;
    logic [3:0]   grp;
    logic         do_end;
    logic         raised;
    logic [3:0]   y;
    logic [3:0]   t;
    logic [2:0]   err_out;

    always_comb
    begin
        nx     = state;
        kind   = KIND_EXTRA;
        grp    = 4'd0;
        do_end = 1'b0;
        raised = 1'b0;
        y      = atr_byte[7:4];
        t      = atr_byte[3:0];

        unique case (state.phase)
            PH_TS:
            begin
                kind = KIND_TS;
                if (atr_byte == TS_INVERSE)
                begin
                    nx.inverse = 1'b1;
                    nx.phase   = PH_T0;
                end
                else if (atr_byte == TS_DIRECT)
                begin
                    nx.inverse = 1'b0;
                    nx.phase   = PH_T0;
                end
                else
                begin
                    nx.err   = ERR_BAD_TS;
                    nx.phase = PH_ERR;
                end
            end
            PH_T0:
            begin
                kind          = KIND_T0;
                nx.pend       = y;
                nx.hist_count = t;
                nx.group      = 4'd1;
                if (y == 4'd0)
                    do_end = 1'b1;
                else
                    nx.phase = PH_IFACE;
            end
            PH_IFACE:
            begin
                grp = state.group;
                priority if (state.pend[0])
                begin
                    kind       = KIND_TA;
                    nx.pend[0] = 1'b0;
                    if (state.group == 4'd2)
                    begin
                        nx.ta2_present = 1'b1;
                        nx.ta2_nibble  = t;
                    end
                end
                else if (state.pend[1])
                begin
                    kind       = KIND_TB;
                    nx.pend[1] = 1'b0;
                end
                else if (state.pend[2])
                begin
                    kind       = KIND_TC;
                    nx.pend[2] = 1'b0;
                end
                else
                begin
                    kind    = KIND_TD;
                    nx.pend = 4'd0;
                    if (state.chosen == PROT_NONE && t != PROTO_T0 && t != PROTO_T1)
                    begin
                        nx.err   = ERR_BAD_TD1;
                        nx.phase = PH_ERR;
                        raised   = 1'b1;
                    end
                    else
                    begin
                        if (state.chosen == PROT_NONE)
                            nx.chosen = (t == PROTO_T0) ? PROT_T0 : PROT_T1;
                        if (t == PROTO_T0)
                            nx.mask[0] = 1'b1;
                        else if (t == PROTO_T1)
                            nx.mask[1] = 1'b1;
                        else if (t == PROTO_T15)
                            nx.mask[2] = 1'b1;
                        // TA2 names the specific mode protocol
                        if (state.group == 4'd2 && state.ta2_present)
                        begin
                            if (state.ta2_nibble == PROTO_T0)
                            begin
                                nx.chosen = PROT_T0;
                                nx.mask   = 3'b001;
                            end
                            else if (state.ta2_nibble == PROTO_T1)
                            begin
                                nx.chosen = PROT_T1;
                                nx.mask   = 3'b010;
                            end
                            else
                            begin
                                nx.err   = ERR_BAD_TA2;
                                nx.phase = PH_ERR;
                                raised   = 1'b1;
                            end
                        end
                        if (!raised && y != 4'd0)
                        begin
                            if (state.group >= MAX_GROUPS)
                            begin
                                nx.err   = ERR_GROUPS;
                                nx.phase = PH_ERR;
                                raised   = 1'b1;
                            end
                            else
                            begin
                                nx.group = 4'(state.group + 4'd1);
                                nx.pend  = y;
                            end
                        end
                    end
                end
                if (!raised && nx.pend == 4'd0)
                    do_end = 1'b1;
            end
            PH_HIST:
            begin
                kind         = KIND_HIST;
                nx.hist_left = 4'(state.hist_left - 4'd1);
                if (nx.hist_left == 4'd0)
                    nx.phase = nx.mask[1] ? PH_TCK : PH_DONE;
            end
            PH_TCK:
            begin
                kind     = KIND_TCK;
                nx.phase = PH_DONE;
            end
            default:
            begin
                kind = KIND_EXTRA;
            end
        endcase

        // end of interface bytes: T=0 by default, then history, and TCK when T=1 is supported
        if (do_end)
        begin
            if (nx.chosen == PROT_NONE)
            begin
                nx.chosen  = PROT_T0;
                nx.mask[0] = 1'b1;
            end
            nx.hist_left = nx.hist_count;
            if (nx.hist_count != 4'd0)
                nx.phase = PH_HIST;
            else
                nx.phase = nx.mask[1] ? PH_TCK : PH_DONE;
        end

        err_out = nx.err;
        if (last_byte && nx.err == ERR_NONE && nx.phase != PH_DONE)
            err_out = ERR_TRUNCATED;

        result.kind             = kind;
        result.group            = grp;
        result.value            = atr_byte;
        result.done             = last_byte;
        result.err              = err_out;
        result.convention       = nx.inverse;
        result.default_protocol = nx.chosen;
        result.supported        = nx.mask;
        result.hist_len         = nx.hist_count;
        result.check_byte       = nx.mask[1];

        state_next = last_byte ? STATE_RESET : nx;
    end

endmodule

// ===== rtl/smart_card_atr_parser_unit.sv =====
// ISO 7816-3 answer-to-reset parser. One ATR byte per transfer in, one classified
// result per transfer out, at up to one byte per clock cycle when not stalled. The
// byte is captured in an input register, then classified by the combinational step
// logic into the result register, which also advances the parse state. The step
// logic between these two registers sets the rate. A byte with tlast ends the ATR
// and returns the parser to its reset state. Result tuser carries byte_kind;
// result tdata carries the running summary (convention, protocols, history length).
module smart_card_atr_parser_unit
    import scap_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] atr_byte
    input  logic        s_tlast,   // last_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [3:0] group_index, [11:4] item_value,
                                   // [14:12] error_code, [15] convention,
                                   // [17:16] default_protocol,
                                   // [20:18] supported_protocols,
                                   // [24:21] history_length,
                                   // [25] check_byte_expected, [31:26] zero
    output logic        m_tlast,   // atr_done
    output logic [3:0]  m_tuser    // [3:0] byte_kind
);

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          in_last_reg;
    logic          out_valid_reg;
    parse_result_t res_reg;
    parse_result_t res_next;
    parse_state_t  state_reg;
    parse_state_t  state_next;
    logic          out_load;
    logic          in_load;

    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign in_load  = s_tvalid && s_tready;

    scap_step u_step
    (
        .state      (state_reg),
        .atr_byte   (in_byte_reg),
        .last_byte  (in_last_reg),
        .state_next (state_next),
        .result     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_RESET;
        end
        else
        begin
            if (in_load)
                in_valid_reg <= 1'b1;
            else if (out_load)
                in_valid_reg <= 1'b0;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (out_load)
            res_reg <= res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = res_reg.done;
    assign m_tuser  = res_reg.kind;
    assign m_tdata  = {6'd0, res_reg.check_byte, res_reg.hist_len, res_reg.supported,
                       res_reg.default_protocol, res_reg.convention, res_reg.err,
                       res_reg.value, res_reg.group};

    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && in_last_reg |=> state_reg.phase == PH_TS)
        else $error("parse state not cleared after last byte");

    a_err_phase: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.err != ERR_NONE |-> state_reg.phase == PH_ERR)
        else $error("latched error without error phase");

    a_group_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.group != 4'd0 && state_reg.group <= MAX_GROUPS)
        else $error("group index out of range");

    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_load |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input stage lost a byte");

endmodule

// ===== verif/atr_result_checker.sv =====
module atr_result_checker
    import scap_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,

    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tlast,
    input  logic [3:0]  m_tuser,

    output int          mismatches,
    output int          outstanding,
    output int          results_checked,
    output int          flagged_atrs
);

    parse_state_t  parser;
    parse_result_t expected_results[$];
    parse_result_t want;

    function automatic void after_history();
        parser.phase = parser.mask[1] ? PH_TCK : PH_DONE;
    endfunction

    function automatic void close_interface();
        if (parser.chosen == PROT_NONE)
        begin
            parser.chosen  = PROT_T0;
            parser.mask[0] = 1'b1;
        end
        parser.hist_left = parser.hist_count;
        if (parser.hist_left != 4'd0)
            parser.phase = PH_HIST;
        else
            after_history();
    endfunction

    function automatic parse_result_t classify_atr_byte(input logic [7:0] b, input logic lst);
        parse_result_t r;
        logic [3:0]    y;
        logic [3:0]    t;
        logic          halted;
        r      = '0;
        r.kind = KIND_EXTRA;
        halted = 1'b0;
        case (parser.phase)
            PH_TS:
            begin
                r.kind = KIND_TS;
                if (b == TS_INVERSE)
                begin
                    parser.inverse = 1'b1;
                    parser.phase   = PH_T0;
                end
                else if (b == TS_DIRECT)
                begin
                    parser.inverse = 1'b0;
                    parser.phase   = PH_T0;
                end
                else
                begin
                    parser.err   = ERR_BAD_TS;
                    parser.phase = PH_ERR;
                end
            end
            PH_T0:
            begin
                r.kind            = KIND_T0;
                parser.pend       = b[7:4];
                parser.hist_count = b[3:0];
                parser.group      = 4'd1;
                if (parser.pend == 4'd0)
                    close_interface();
                else
                    parser.phase = PH_IFACE;
            end
            PH_IFACE:
            begin
                r.group = parser.group;
                if (parser.pend[0])
                begin
                    r.kind         = KIND_TA;
                    parser.pend[0] = 1'b0;
                    if (parser.group == 4'd2)
                    begin
                        parser.ta2_present = 1'b1;
                        parser.ta2_nibble  = b[3:0];
                    end
                end
                else if (parser.pend[1])
                begin
                    r.kind         = KIND_TB;
                    parser.pend[1] = 1'b0;
                end
                else if (parser.pend[2])
                begin
                    r.kind         = KIND_TC;
                    parser.pend[2] = 1'b0;
                end
                else
                begin
                    y           = b[7:4];
                    t           = b[3:0];
                    r.kind      = KIND_TD;
                    parser.pend = 4'd0;
                    // first TD fixes the default protocol
                    if (parser.chosen == PROT_NONE)
                    begin
                        if (t == PROTO_T0)
                            parser.chosen = PROT_T0;
                        else if (t == PROTO_T1)
                            parser.chosen = PROT_T1;
                        else
                        begin
                            parser.err   = ERR_BAD_TD1;
                            parser.phase = PH_ERR;
                            halted       = 1'b1;
                        end
                    end
                    if (!halted)
                    begin
                        if (t == PROTO_T0)
                            parser.mask[0] = 1'b1;
                        else if (t == PROTO_T1)
                            parser.mask[1] = 1'b1;
                        else if (t == PROTO_T15)
                            parser.mask[2] = 1'b1;
                        // TA2 present: specific mode overrides
                        if (parser.group == 4'd2 && parser.ta2_present)
                        begin
                            if (parser.ta2_nibble == PROTO_T0)
                            begin
                                parser.chosen = PROT_T0;
                                parser.mask   = 3'b001;
                            end
                            else if (parser.ta2_nibble == PROTO_T1)
                            begin
                                parser.chosen = PROT_T1;
                                parser.mask   = 3'b010;
                            end
                            else
                            begin
                                parser.err   = ERR_BAD_TA2;
                                parser.phase = PH_ERR;
                                halted       = 1'b1;
                            end
                        end
                    end
                    if (!halted && y != 4'd0)
                    begin
                        if (parser.group >= MAX_GROUPS)
                        begin
                            parser.err   = ERR_GROUPS;
                            parser.phase = PH_ERR;
                            halted       = 1'b1;
                        end
                        else
                        begin
                            parser.group = parser.group + 4'd1;
                            parser.pend  = y;
                        end
                    end
                end
                if (!halted && parser.pend == 4'd0)
                    close_interface();
            end
            PH_HIST:
            begin
                r.kind           = KIND_HIST;
                parser.hist_left = parser.hist_left - 4'd1;
                if (parser.hist_left == 4'd0)
                    after_history();
            end
            PH_TCK:
            begin
                r.kind       = KIND_TCK;
                parser.phase = PH_DONE;
            end
            default:
                r.kind = KIND_EXTRA;
        endcase

        r.value = b;
        r.done  = lst;
        r.err   = parser.err;
        if (lst && parser.err == ERR_NONE && parser.phase != PH_DONE)
            r.err = ERR_TRUNCATED;
        r.convention       = parser.inverse;
        r.default_protocol = parser.chosen;
        r.supported        = parser.mask;
        r.hist_len         = parser.hist_count;
        r.check_byte       = parser.mask[1];
        if (lst)
            parser = STATE_RESET;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            mismatches = mismatches + 1;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parser = STATE_RESET;
            expected_results.delete();
            mismatches      = 0;
            results_checked = 0;
            flagged_atrs    = 0;
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    $display("%0t: result transfer, expected none, actual kind %0h data %h",
                             $time, m_tuser, m_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("byte_kind", 8'(want.kind), 8'(m_tuser));
                    check_field("group_index", 8'(want.group), 8'(m_tdata[3:0]));
                    check_field("item_value", want.value, m_tdata[11:4]);
                    check_field("atr_done", 8'(want.done), 8'(m_tlast));
                    check_field("error_code", 8'(want.err), 8'(m_tdata[14:12]));
                    check_field("convention", 8'(want.convention), 8'(m_tdata[15]));
                    check_field("default_protocol", 8'(want.default_protocol),
                                8'(m_tdata[17:16]));
                    check_field("supported_protocols", 8'(want.supported),
                                8'(m_tdata[20:18]));
                    check_field("history_length", 8'(want.hist_len), 8'(m_tdata[24:21]));
                    check_field("check_byte_expected", 8'(want.check_byte),
                                8'(m_tdata[25]));
                    check_field("tdata padding", 8'd0, 8'(m_tdata[31:26]));
                    results_checked = results_checked + 1;
                    if (want.done && want.err != ERR_NONE)
                        flagged_atrs = flagged_atrs + 1;
                end
            end
            if (s_tvalid && s_tready)
                expected_results.push_back(classify_atr_byte(s_tdata, s_tlast));
            outstanding <= expected_results.size();
        end
    end

endmodule

// ===== verif/tb_smart_card_atr_parser_unit.sv =====
module tb_smart_card_atr_parser_unit;
    import scap_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int HOLD_CYCLES  = 400;
    localparam int ITEMS_TARGET = 850;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;
    logic [3:0]  m_tuser;

    int mismatches;
    int outstanding;
    int results_checked;
    int flagged_atrs;

    logic [7:0] atr_q[$];
    int         bytes_sent = 0;
    int         atr_count  = 0;
    int         send_idle  = 0;
    int         recv_stall = 0;
    int         cycles     = 0;
    bit         hold_req   = 1'b0;
    bit         hold_done  = 1'b0;
    int         phase;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    smart_card_atr_parser_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    atr_result_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .m_tuser         (m_tuser),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .flagged_atrs    (flagged_atrs)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, outstanding);
            $display("tb_smart_card_atr_parser_unit failed");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic lst);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent = bytes_sent + 1;
    endtask

    task automatic flush_atr();
        int i;
        for (i = 0; i < atr_q.size(); i++)
            send_byte(atr_q[i], i == atr_q.size() - 1);
        atr_q.delete();
        atr_count = atr_count + 1;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // mostly well-formed ATRs with random content; some truncated, overlong or noise
    task automatic build_atr();
        logic [3:0] y;
        logic [3:0] nxt;
        logic [3:0] t;
        logic [3:0] k;
        logic [7:0] b;
        int         g;
        int         depth;
        int         r;
        int         i;
        bit         more;
        bit         t1;
        r = $urandom_range(99);
        if (r < 8)
        begin
            repeat ($urandom_range(1, 10))
                atr_q.push_back(8'($urandom_range(255)));
            return;
        end
        r = $urandom_range(99);
        atr_q.push_back(r < 48 ? TS_DIRECT : (r < 96 ? TS_INVERSE : 8'($urandom_range(255))));
        k     = ($urandom_range(3) != 0) ? 4'($urandom_range(4)) : 4'($urandom_range(15));
        depth = ($urandom_range(99) < 85) ? $urandom_range(1, 4) : $urandom_range(5, 10);
        y     = 4'($urandom_range(15));
        if (depth > 1)
            y[3] = 1'b1;
        atr_q.push_back({y, k});
        g    = 1;
        more = (y != 4'd0);
        t1   = 1'b0;
        while (more)
        begin
            if (y[0])
            begin
                b = 8'($urandom_range(255));
                if (g == 2 && $urandom_range(9) < 7)
                    b[3:0] = 4'($urandom_range(1));
                if (g == 2)
                    t = b[3:0];
                atr_q.push_back(b);
            end
            if (y[1])
                atr_q.push_back(8'($urandom_range(255)));
            if (y[2])
                atr_q.push_back(8'($urandom_range(255)));
            more = 1'b0;
            if (y[3])
            begin
                r = $urandom_range(9);
                if (g == 1)
                    nxt = (r < 9) ? 4'($urandom_range(1)) : 4'($urandom_range(2, 14));
                else
                    nxt = (r < 3) ? PROTO_T0 : (r < 6) ? PROTO_T1 : (r < 8) ? PROTO_T15
                        : 4'($urandom_range(15));
                if (nxt == PROTO_T1)
                    t1 = 1'b1;
                if (g == 2 && y[0] == 1'b0)
                    t = 4'd2;
                if (g == 2 && y[0])
                    t1 = (t == PROTO_T1);
                b[3:0] = nxt;
                b[7:4] = 4'd0;
                if (g < depth)
                begin
                    b[7:4] = 4'($urandom_range(15));
                    b[7]   = (g + 1 < depth);
                end
                atr_q.push_back(b);
                if (b[7:4] != 4'd0)
                begin
                    y    = b[7:4];
                    g    = g + 1;
                    more = 1'b1;
                end
            end
        end
        for (i = 0; i < k; i++)
            atr_q.push_back(8'($urandom_range(255)));
        if (t1)
            atr_q.push_back(8'($urandom_range(255)));
        r = $urandom_range(99);
        if (r < 12 && atr_q.size() > 1)
        begin
            i = $urandom_range(1, atr_q.size() - 1);
            while (atr_q.size() > i)
                void'(atr_q.pop_back());
        end
        else if (r < 24)
        begin
            repeat ($urandom_range(1, 3))
                atr_q.push_back(8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // minimal direct ATR with a trailing extra byte
        atr_q = '{TS_DIRECT, 8'h00, 8'hAA};
        flush_atr();
        // inverse, all four interface bytes, TA2 forcing T=0 over T=1 and T=15
        atr_q = '{TS_INVERSE, 8'hF2, 8'hFF, 8'h00, 8'h80, 8'h91, 8'h80, 8'h0F,
                  8'h00, 8'hFF};
        flush_atr();
        // bad TS
        atr_q = '{8'h00, 8'h3B, 8'hFF};
        flush_atr();
        // first TD names T=2
        atr_q = '{TS_DIRECT, 8'h80, 8'h02, 8'hFF};
        flush_atr();
        // truncated before the history
        atr_q = '{TS_DIRECT, 8'h81, 8'h01};
        flush_atr();
        // TA2 names an unusable protocol
        atr_q = '{TS_DIRECT, 8'h80, 8'h90, 8'h05, 8'h00};
        flush_atr();
        drain();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle  = 0;
                    recv_stall = 0;
                    hold_req   = 1'b1;
                end
                1:
                begin
                    send_idle  = 86;
                    recv_stall = 0;
                end
                2:
                begin
                    send_idle  = 0;
                    recv_stall = 86;
                end
                default:
                begin
                    send_idle  = 15;
                    recv_stall = 15;
                end
            endcase
            while (bytes_sent < 25 + (phase + 1) * (ITEMS_TARGET / 4))
            begin
                build_atr();
                flush_atr();
            end
            drain();
        end

        repeat (10) @(posedge clk);
        $display("%0d bytes in %0d ATRs over four flow-control phases and a long result hold-off",
                 bytes_sent, atr_count);
        $display("%0d results checked, %0d ATRs ended with an error code",
                 results_checked, flagged_atrs);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_smart_card_atr_parser_unit passed");
        else
            $display("tb_smart_card_atr_parser_unit failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/scap_pkg.sv
rtl/scap_step.sv
rtl/smart_card_atr_parser_unit.sv
verif/atr_result_checker.sv
verif/tb_smart_card_atr_parser_unit.sv
